@@ src/ffa_pkg.sv @@
// Package for the first-fit region allocator.
// Holds sizes, codes, item structs and the structs passed between the top level and the cells.
`default_nettype none

package ffa_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int PAGE_SHIFT  = 12;
    localparam int ADDR_W      = 32;

    // Page rounding works on 33 bits so that requests near 2^32 round to 2^32.
    localparam logic [ADDR_W:0] PAGE_MASK = (33'd1 << PAGE_SHIFT) - 33'd1;
    localparam logic [ADDR_W:0] ADDR_LIMIT = 33'h1_0000_0000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTES = 1'd1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NOFIT       = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_NOTALLOC    = 3'd3,
        STAT_DISABLED    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_APPLY
    } fsm_t;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [2:0]        status;
    } rsp_t;

    // Broadcast to every cell during evaluation.
    typedef struct packed {
        logic              alloc;
        logic [ADDR_W:0]   rounded;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W:0]   win_end;
    } bcast_t;

    // Per-cell update command.
    typedef struct packed {
        logic eval;
        logic take_new;
        logic take_left;
        logic take_right;
    } cell_ctl_t;

    // Contents of one table entry as seen by the neighbors.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W:0]   end_addr;
    } cell_t;

endpackage

`default_nettype wire

@@ src/ffa_cell.sv @@
// One table entry of the first-fit region allocator.
// Uses ffa_pkg; checks the gap in front of itself and shifts with its neighbors.
`default_nettype none

module ffa_cell
    import ffa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire bcast_t    bcast,
    input  wire cell_ctl_t ctl,
    input  wire cell_t     left,
    input  wire cell_t     right,
    output cell_t          entry,
    output logic           hit,
    output logic [ADDR_W-1:0] gap_lo
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W:0]   end_reg, end_next;
    logic              hit_reg;
    logic [ADDR_W:0]   gap_lo_reg;
    logic [ADDR_W:0]   cand_end_reg;

    logic [ADDR_W:0]   gap_hi;
    logic [ADDR_W+1:0] cand_end;
    logic              fit;
    logic              match;

    // The gap in front of this entry starts at the left neighbor's end. When the
    // left neighbor is the last entry, this slot is the gap up to the window end.
    always_comb begin
        gap_hi   = valid_reg ? {1'b0, start_reg} : bcast.win_end;
        cand_end = {1'b0, left.end_addr} + {1'b0, bcast.rounded};
        fit      = left.valid && !left.end_addr[ADDR_W] && !bcast.rounded[ADDR_W]
                   && ({1'b0, gap_hi} >= cand_end);
        match    = valid_reg && (start_reg == bcast.addr);
    end

    always_ff @(posedge aclk) begin
        if (ctl.eval) begin
            hit_reg      <= bcast.alloc ? fit : match;
            gap_lo_reg   <= left.end_addr;
            cand_end_reg <= cand_end[ADDR_W:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        start_next = start_reg;
        end_next   = end_reg;
        if (ctl.take_new) begin
            valid_next = 1'b1;
            start_next = gap_lo_reg[ADDR_W-1:0];
            end_next   = cand_end_reg;
        end else if (ctl.take_left) begin
            valid_next = left.valid;
            start_next = left.start;
            end_next   = left.end_addr;
        end else if (ctl.take_right) begin
            valid_next = right.valid;
            start_next = right.start;
            end_next   = right.end_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign entry  = '{valid: valid_reg, start: start_reg, end_addr: end_reg};
    assign hit    = hit_reg;
    assign gap_lo = gap_lo_reg[ADDR_W-1:0];

endmodule

`default_nettype wire

@@ src/first_fit_region_allocator_top.sv @@
// Top level of the first-fit region allocator: handshakes, sequencer and the row of cells.
// Uses ffa_pkg and ffa_cell.
//
//  channel | ports                    | moves
//  --------+--------------------------+-------------------------------------
//  input   | s_valid s_ready s_data   | one allocate or free request
//  result  | m_valid m_ready m_data   | granted address and status
//  config  | cfg_we cfg_index cfg_wdata | window base and window size
//
// Each item is accepted, then every cell is evaluated in parallel, then the
// row is updated and the result register loaded. The next item is taken in the
// cycle after the update. An update waits while an earlier result is still
// held in the output register. Reset empties the table at once.
`default_nettype none

module first_fit_region_allocator_top
    import ffa_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire req_t                 s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rsp_t                      m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_wdata
);

    fsm_t              state_reg, state_next;
    logic [ADDR_W-1:0] base_reg, bytes_reg;
    logic              alloc_reg;
    logic [ADDR_W:0]   rounded_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              tail_hit_reg;
    logic              m_valid_reg;
    rsp_t              m_data_reg;

    logic              eval;
    logic              apply_go;
    bcast_t            bcast;
    logic [ADDR_W:0]   win_end_full;
    logic [ADDR_W:0]   rounded_next;

    cell_t                 entries [MAX_REGIONS];
    cell_ctl_t             ctls    [MAX_REGIONS];
    logic [ADDR_W-1:0]     gaps    [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] hits, first, after;

    logic              enabled, full, any_hit, tail_fit;
    logic [ADDR_W-1:0] grant_addr;
    rsp_t              rsp;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            bytes_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WINDOW_BASE:  base_reg  <= cfg_wdata;
                CFG_WINDOW_BYTES: bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:  if (s_valid) state_next = FSM_EVAL;
            FSM_EVAL:  state_next = FSM_APPLY;
            FSM_APPLY: if (!m_valid_reg || m_ready) state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        eval     = 1'b0;
        apply_go = 1'b0;
        case (state_reg)
            FSM_IDLE:  s_ready  = 1'b1;
            FSM_EVAL:  eval     = 1'b1;
            FSM_APPLY: apply_go = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request registers.
    assign rounded_next = ({1'b0, s_data.request_bytes} + PAGE_MASK) & ~PAGE_MASK;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            alloc_reg   <= (s_data.opcode == OP_ALLOC);
            rounded_reg <= rounded_next;
            addr_reg    <= s_data.free_address;
        end
    end

    always_comb begin
        win_end_full  = {1'b0, base_reg} + {1'b0, bytes_reg};
        bcast.alloc   = alloc_reg;
        bcast.rounded = rounded_reg;
        bcast.addr    = addr_reg;
        bcast.win_end = (win_end_full > ADDR_LIMIT) ? ADDR_LIMIT : win_end_full;
    end

    // Row of cells; each one sees its left and right neighbor.
    genvar g;
    generate
        for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
            cell_t left_in, right_in;
            if (g == 0) begin : g_first
                assign left_in = '{valid: 1'b1, start: '0, end_addr: {1'b0, base_reg}};
            end else begin : g_mid
                assign left_in = entries[g-1];
            end
            if (g == MAX_REGIONS - 1) begin : g_last
                assign right_in = '{valid: 1'b0, start: '0, end_addr: '0};
            end else begin : g_next
                assign right_in = entries[g+1];
            end

            assign ctls[g].eval       = eval;
            assign ctls[g].take_new   = apply_go && enabled && alloc_reg && !full && first[g];
            assign ctls[g].take_left  = apply_go && enabled && alloc_reg && !full
                                        && after[g] && !first[g];
            assign ctls[g].take_right = apply_go && enabled && !alloc_reg && after[g];

            ffa_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .bcast   (bcast),
                .ctl     (ctls[g]),
                .left    (left_in),
                .right   (right_in),
                .entry   (entries[g]),
                .hit     (hits[g]),
                .gap_lo  (gaps[g])
            );
        end
    endgenerate

    // The gap behind the last entry exists only when the table is full.
    assign tail_fit = entries[MAX_REGIONS-1].valid
                      && !entries[MAX_REGIONS-1].end_addr[ADDR_W] && !rounded_reg[ADDR_W]
                      && ({1'b0, bcast.win_end}
                          >= ({1'b0, entries[MAX_REGIONS-1].end_addr} + {1'b0, rounded_reg}));

    always_ff @(posedge aclk) begin
        if (eval) begin
            tail_hit_reg <= alloc_reg && tail_fit;
        end
    end

    // Lowest hit, and the mask of that hit and every entry above it.
    always_comb begin
        first = hits & (~hits + 1'b1);
        after = hits | (~hits + 1'b1);
    end

    always_comb begin
        grant_addr = '0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            grant_addr = grant_addr | (gaps[i] & {ADDR_W{first[i]}});
        end
    end

    always_comb begin
        enabled = (bytes_reg != '0);
        full    = entries[MAX_REGIONS-1].valid;
        any_hit = (hits != '0) || tail_hit_reg;
        rsp.granted_address = '0;
        rsp.status          = STAT_OK;
        if (!enabled) begin
            rsp.status = STAT_DISABLED;
        end else if (alloc_reg) begin
            if (!any_hit) begin
                rsp.status = STAT_NOFIT;
            end else if (full) begin
                rsp.status = STAT_FULL;
            end else begin
                rsp.granted_address = grant_addr;
            end
        end else if (hits == '0) begin
            rsp.status = STAT_NOTALLOC;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (apply_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ src/ffa_checker.sv @@
// Port-level checks for the first-fit region allocator.
// Uses ffa_pkg; bound to first_fit_region_allocator_top at the end of this file.
`default_nettype none

module ffa_checker
    import ffa_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire rsp_t m_data
);

    // Only one item is at work at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another was at work");

    // A result follows an accepted item no sooner than the update cycle.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared without evaluation");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= 3'd4))
        else $error("status code out of range");

    // Only a granted allocation carries an address.
    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STAT_OK) |-> (m_data.granted_address == '0))
        else $error("address given with a failing status");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind first_fit_region_allocator_top ffa_checker u_ffa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
